FILE: design/sswc_pkg.sv
`default_nettype none

package sswc_pkg;

    localparam int DEF_CAPACITY = 256;
    localparam int KEY_W        = 64;
    localparam int GRP_SIZE     = 16;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_LOCATE  = 3'd1;
    localparam logic [2:0] OP_FIRST   = 3'd2;
    localparam logic [2:0] OP_NEXT    = 3'd3;
    localparam logic [2:0] OP_CURRENT = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             upd_en;
        logic             ins_ok;
        logic [2:0]       op;
        logic [KEY_W-1:0] key;
        logic [7:0]       idx;
    } ctl_t;

    // per-cell flags gathered by the sequencer
    typedef struct packed {
        logic eq;
        logic flag;
        logic next_ok;
    } cell_stat_t;

endpackage

`default_nettype wire

FILE: design/sswc_cell.sv
`default_nettype none

module sswc_cell
    import sswc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctl_t             ctl,
    input  wire logic [CW-1:0]    count,
    input  wire logic             prev_less,
    input  wire logic [KEY_W-1:0] prev_key,
    input  wire logic             prev_flag,
    output logic                  less,
    output logic [KEY_W-1:0]      key,
    output logic                  flag,
    output cell_stat_t            stat,
    output logic [KEY_W-1:0]      data
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             flag_reg;
    logic             flag_next;
    logic             less_reg;
    logic             eq_reg;
    logic             occ;
    logic             last;
    logic             idx_hit;
    logic             sel;

    assign occ  = count > CW'(INDEX);
    assign last = occ && !(count > CW'(INDEX + 1));
    assign idx_hit = (INDEX < 256) && (ctl.idx == 8'(INDEX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg <= 1'b0;
            eq_reg   <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            less_reg <= occ && ($signed(key_reg) < $signed(ctl.key));
            eq_reg   <= occ && (key_reg == ctl.key);
        end
    end

    always_comb
    begin
        key_next  = key_reg;
        flag_next = flag_reg;
        if (ctl.upd_en)
        begin
            case (ctl.op)
                OP_INSERT:
                begin
                    // entries at and above the ceiling move up one place
                    if (ctl.ins_ok && !less_reg)
                    begin
                        key_next  = prev_less ? ctl.key : prev_key;
                        flag_next = prev_less ? 1'b0 : prev_flag;
                    end
                end
                OP_LOCATE:
                    flag_next = occ && ((!less_reg && prev_less) || (less_reg && last));
                OP_FIRST:
                    flag_next = occ && (INDEX == 0);
                OP_NEXT:
                    flag_next = prev_flag && occ;
                default:
                begin
                    key_next  = key_reg;
                    flag_next = flag_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flag_reg <= 1'b0;
        else
            flag_reg <= flag_next;
    end

    always_comb
    begin
        case (ctl.op)
            OP_LOCATE, OP_FIRST, OP_NEXT, OP_CURRENT: sel = flag_reg;
            OP_READ:                                  sel = occ && idx_hit;
            default:                                  sel = 1'b0;
        endcase
    end

    assign less         = less_reg;
    assign key          = key_reg;
    assign flag         = flag_reg;
    assign stat.eq      = eq_reg;
    assign stat.flag    = flag_reg;
    assign stat.next_ok = prev_flag && occ;
    assign data         = sel ? key_reg : '0;

endmodule

`default_nettype wire

FILE: design/sswc_gather.sv
`default_nettype none

module sswc_gather
    import sswc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic             clk,
    input  wire logic             load,
    input  wire logic [KEY_W-1:0] cell_data [CAPACITY],
    output logic [KEY_W-1:0]      value
);

    localparam int NG = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    logic [KEY_W-1:0] grp_reg  [NG];
    logic [KEY_W-1:0] grp_next [NG];

    // at most one cell drives nonzero data, so an or-tree selects it
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < CAPACITY)
                    grp_next[g] = grp_next[g] | cell_data[g * GRP_SIZE + j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NG; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        value = '0;
        for (int g = 0; g < NG; g++)
            value = value | grp_reg[g];
    end

endmodule

`default_nettype wire

FILE: design/sorted_set_with_cursor.sv
`default_nettype none

// Sorted set of distinct signed Q32.32 keys with a cursor, held in a row of
// compare-and-shift cells, one key per cell. A request is taken when start is
// high and busy is low; its single result appears on result_value, status and
// entry_count for exactly one cycle while done is high, and must be taken
// then. For every request, whatever the
// fill, every cell compares at the accepting edge, the row shifts or moves
// the cursor mark in the next cycle, and the selected key is gathered through
// a two-stage registered or-tree. A new request may be given in the cycle in
// which done is high. Key storage needs no clearing after reset.
module sorted_set_with_cursor
    import sswc_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [63:0] key_value,
    input  wire logic [7:0]         read_index,
    output logic                    done,
    output logic signed [63:0]      result_value,
    output logic [2:0]              status,
    output logic [8:0]              entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_RD1  = 2'd2;
    localparam logic [1:0] S_RD2  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [2:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [7:0]       idx_reg;
    logic [2:0]       st_reg;
    logic [2:0]       st_next;
    logic             done_reg;
    logic [KEY_W-1:0] value_reg;
    logic [2:0]       status_reg;
    logic [CW-1:0]    count_out_reg;

    ctl_t             ctl;
    logic             accept;
    logic             dup;
    logic             any_flag;
    logic             any_next;
    logic             full;
    logic [KEY_W-1:0] gathered;

    logic             chain_less [CAPACITY+1];
    logic [KEY_W-1:0] chain_key  [CAPACITY+1];
    logic             chain_flag [CAPACITY+1];
    cell_stat_t       stat       [CAPACITY];
    logic [KEY_W-1:0] cell_data  [CAPACITY];

    assign accept = start && (state_reg == S_IDLE);

    assign ctl.cmp_en = accept;
    assign ctl.upd_en = (state_reg == S_UPD);
    assign ctl.ins_ok = !dup && !full;
    assign ctl.op     = op_reg;
    assign ctl.key    = (state_reg == S_IDLE) ? key_value : key_reg;
    assign ctl.idx    = idx_reg;

    assign chain_less[0] = 1'b1;
    assign chain_key[0]  = ctl.key;
    assign chain_flag[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sswc_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count_reg),
            .prev_less (chain_less[i]),
            .prev_key  (chain_key[i]),
            .prev_flag (chain_flag[i]),
            .less      (chain_less[i+1]),
            .key       (chain_key[i+1]),
            .flag      (chain_flag[i+1]),
            .stat      (stat[i]),
            .data      (cell_data[i])
        );
    end

    sswc_gather #(
        .CAPACITY (CAPACITY)
    ) u_gather (
        .clk       (clk),
        .load      (state_reg == S_RD1),
        .cell_data (cell_data),
        .value     (gathered)
    );

    always_comb
    begin
        dup      = 1'b0;
        any_flag = 1'b0;
        any_next = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            dup      = dup | stat[i].eq;
            any_flag = any_flag | stat[i].flag;
            any_next = any_next | stat[i].next_ok;
        end
    end

    assign full = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        count_next = count_reg;
        st_next    = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                // duplicate check wins over the full check
                if (dup)
                    st_next = ST_DUP;
                else if (full)
                    st_next = ST_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            OP_LOCATE, OP_FIRST:
                st_next = (count_reg == '0) ? ST_EMPTY : ST_OK;
            OP_NEXT:
                st_next = any_next ? ST_OK : ST_EMPTY;
            OP_CURRENT:
                st_next = any_flag ? ST_OK : ST_EMPTY;
            OP_READ:
                st_next = (32'(idx_reg) < 32'(count_reg)) ? ST_OK : ST_RANGE;
            default:
                st_next = ST_OK;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_UPD : S_IDLE;
            S_UPD:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPD)
                count_reg <= count_next;
            done_reg <= (state_reg == S_RD2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key_value;
            idx_reg <= read_index;
        end
        if (state_reg == S_UPD)
            st_reg <= st_next;
        if (state_reg == S_RD2)
        begin
            value_reg     <= gathered;
            status_reg    <= st_reg;
            count_out_reg <= count_reg;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign entry_count  = 9'(count_out_reg);

endmodule

`default_nettype wire

FILE: design/sswc_checker.sv
`default_nettype none

module sswc_checker
    import sswc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire logic signed [63:0] result_value,
    input wire logic [2:0]         status
);

    // each accepted request must be answered with done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result not delivered four cycles after request");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_DUP || status == ST_FULL ||
                  status == ST_EMPTY || status == ST_RANGE))
        else $error("status code out of range");

    // an empty or out-of-range status carries a zero value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_EMPTY || status == ST_RANGE) |-> result_value == 64'sd0)
        else $error("nonzero value with failing status");

endmodule

bind sorted_set_with_cursor sswc_checker u_sswc_checker (.*);

`default_nettype wire
